@@ hdl/odd_even_transposition_sort_defines.svh @@
// Assertion macros shared by the sorter modules.
`ifndef ODD_EVEN_TRANSPOSITION_SORT_DEFINES_SVH
`define ODD_EVEN_TRANSPOSITION_SORT_DEFINES_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define OETS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("sorter assertion failed");

// Expression must never be true outside reset.
`define OETS_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("sorter forbidden condition seen");

`else

`define OETS_ASSERT(lbl, clk, rst, prop)
`define OETS_ASSERT_NEVER(lbl, clk, rst, expr)

`endif

`endif

@@ hdl/oets_pkg.sv @@
// Shared constants and command/status types of the odd-even transposition sorter.
package oets_pkg;

   localparam int CAPACITY = 64;
   localparam int VALUE_W  = 32;
   localparam int COUNT_W  = $clog2(CAPACITY + 1);

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [COUNT_W-1:0]        count_type;

   typedef struct packed {
      logic load;
      logic phase_en;
      logic phase_odd;
      logic shift;
   } cmd_type;

   typedef struct packed {
      logic swapped;
      logic count_one;
   } status_type;

endpackage

@@ hdl/oets_req_if.sv @@
// Request channel: one element and its end-of-batch mark.
interface oets_req_if;
   import oets_pkg::*;

   logic      valid;
   logic      ready;
   value_type value;
   logic      last;

   modport source (output valid, output value, output last, input ready);
   modport sink (input valid, input value, input last, output ready);
endinterface

@@ hdl/oets_rsp_if.sv @@
// Response channel: one sorted element with its flags.
interface oets_rsp_if;
   import oets_pkg::*;

   logic      valid;
   logic      ready;
   value_type sorted_value;
   logic      final_res;
   logic      overflow;

   modport source (output valid, output sorted_value, output final_res, output overflow,
                   input ready);
   modport sink (input valid, input sorted_value, input final_res, input overflow,
                 output ready);
endinterface

@@ hdl/oets_ctrl.sv @@
// Controller: load, odd and even phases, emission.
`include "odd_even_transposition_sort_defines.svh"

module oets_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  oets_pkg::status_type status,
   output oets_pkg::cmd_type    cmd
);
   import oets_pkg::*;

   typedef enum logic [3:0] {
      ST_LOAD = 4'b0001,
      ST_ODD  = 4'b0010,
      ST_EVEN = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      swap_odd_ff, swap_odd_in;

   assign req_ready     = (state_ff == ST_LOAD);
   assign rsp_valid     = (state_ff == ST_EMIT);
   assign cmd.load      = req_valid && req_ready;
   assign cmd.phase_en  = (state_ff == ST_ODD) || (state_ff == ST_EVEN);
   assign cmd.phase_odd = (state_ff == ST_ODD);
   assign cmd.shift     = rsp_valid && rsp_ready;

   always_comb begin
      state_in    = state_ff;
      swap_odd_in = swap_odd_ff;
      case (state_ff)
         ST_LOAD: begin
            if (cmd.load && req_last) begin
               state_in = ST_ODD;
            end
         end
         ST_ODD: begin
            swap_odd_in = status.swapped;
            state_in    = ST_EVEN;
         end
         ST_EVEN: begin
            // stop after a full round without a swap
            if (swap_odd_ff || status.swapped) begin
               state_in = ST_ODD;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (cmd.shift && status.count_one) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         swap_odd_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         swap_odd_ff <= swap_odd_in;
      end
   end

   `OETS_ASSERT(a_clean_round_emits, clock, reset,
      (state_ff == ST_EVEN) && !swap_odd_ff && !status.swapped |=> rsp_valid)
   `OETS_ASSERT(a_last_request_closes, clock, reset,
      cmd.load && req_last |=> !req_ready)

endmodule

@@ hdl/oets_datapath.sv @@
// Datapath: row of element cells with neighbour compare-exchange, count and drop flag.
`include "odd_even_transposition_sort_defines.svh"

module oets_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  oets_pkg::cmd_type    cmd,
   input  oets_pkg::value_type  req_value,
   output oets_pkg::value_type  rsp_sorted_value,
   output logic                 rsp_final_res,
   output logic                 rsp_overflow,
   output oets_pkg::status_type status
);
   import oets_pkg::*;

   value_type cell_ff [CAPACITY];
   value_type cell_in [CAPACITY];
   count_type count_ff, count_in;
   logic      dropped_ff, dropped_in;
   logic      full;
   logic      swapped;

   assign full = (count_ff == count_type'(CAPACITY));

   always_comb begin
      cell_in    = cell_ff;
      count_in   = count_ff;
      dropped_in = dropped_ff;
      swapped    = 1'b0;
      if (cmd.load) begin
         if (full) begin
            dropped_in = 1'b1;
         end else begin
            for (int i = 0; i < CAPACITY; i++) begin
               if (count_type'(i) == count_ff) begin
                  cell_in[i] = req_value;
               end
            end
            count_in = count_ff + count_type'(1);
         end
      end else if (cmd.phase_en) begin
         // pairs of one phase are disjoint, so all exchange at once
         for (int i = 0; i < CAPACITY - 1; i++) begin
            if ((1'(i) == cmd.phase_odd) && (count_type'(i + 1) < count_ff) &&
                (cell_ff[i] > cell_ff[i+1])) begin
               cell_in[i]   = cell_ff[i+1];
               cell_in[i+1] = cell_ff[i];
               swapped      = 1'b1;
            end
         end
      end else if (cmd.shift) begin
         // advance the row towards the output cell
         for (int i = 0; i < CAPACITY - 1; i++) begin
            cell_in[i] = cell_ff[i+1];
         end
         count_in = count_ff - count_type'(1);
         if (count_ff == count_type'(1)) begin
            dropped_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
      end
   end

   assign status.swapped   = swapped;
   assign status.count_one = (count_ff == count_type'(1));
   assign rsp_sorted_value = cell_ff[0];
   assign rsp_final_res    = status.count_one;
   assign rsp_overflow     = dropped_ff;

   `OETS_ASSERT_NEVER(a_count_bound, clock, reset, count_ff > count_type'(CAPACITY))
   `OETS_ASSERT(a_batch_end_clears, clock, reset,
      cmd.shift && status.count_one |=> (count_ff == '0) && !dropped_ff)

endmodule

@@ hdl/odd_even_transposition_sort.sv @@
// Odd-even transposition sorter of signed 32-bit batches, up to 64 elements each.
// Requests are taken one per cycle while a batch loads; elements past 64 are dropped and
// flag the whole batch as overflowed. After the last request the block takes no request
// until the batch has left: the element row runs one compare-exchange phase per cycle,
// an odd and an even phase per round, until a round makes no swap, then gives one
// response per kept element at one per cycle while the sink is ready.
module odd_even_transposition_sort (
   input logic       clock,
   input logic       reset,
   oets_req_if.sink  req_ch,
   oets_rsp_if.source rsp_ch
);
   import oets_pkg::*;

   cmd_type    cmd;
   status_type status;

   oets_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_last  (req_ch.last),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   oets_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_value        (req_ch.value),
      .rsp_sorted_value (rsp_ch.sorted_value),
      .rsp_final_res    (rsp_ch.final_res),
      .rsp_overflow     (rsp_ch.overflow),
      .status           (status)
   );

endmodule

@@ tb/odd_even_transposition_sort_tb.sv @@
// Self-checking testbench for the odd-even transposition sorter: batches in, sorted batches out.
module odd_even_transposition_sort_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import oets_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 400;
   localparam int IDLE_PERCENT = 21;
   localparam int TAIL_CYCLES  = 2 * CAPACITY + 8;
   localparam int ITEM_TARGET  = 500;

   typedef struct {
      value_type value;
      logic      last;
   } element_req_type;

   typedef struct {
      value_type sorted_value;
      logic      final_res;
      logic      overflow;
   } sorted_elem_type;

   logic clock;
   logic reset;

   oets_req_if req_bus ();
   oets_rsp_if rsp_bus ();

   odd_even_transposition_sort uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   element_req_type element_feed [$];
   sorted_elem_type sorted_due [$];

   // predictor state: one batch being collected
   value_type batch_store [CAPACITY];
   int        batch_count;
   bit        batch_dropped;

   bit no_idle;
   int hold_requests;
   int holds_served;
   int hold_left;
   int cycle_count;
   int error_count;
   int items_queued;
   int requests_taken;
   int batches_done;
   int overflow_batches;
   int results_checked;

   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.value = '0;
      req_bus.last  = 1'b0;
      rsp_bus.ready = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // Sort the collected batch by alternating odd and even compare-exchange passes.
   function automatic void sort_batch(int n);
      bit        swapped;
      value_type t;
      int        i;
      swapped = 1'b1;
      while (swapped) begin
         swapped = 1'b0;
         for (i = 1; i + 1 < n; i += 2) begin
            if (batch_store[i] > batch_store[i+1]) begin
               t = batch_store[i];
               batch_store[i] = batch_store[i+1];
               batch_store[i+1] = t;
               swapped = 1'b1;
            end
         end
         for (i = 0; i + 1 < n; i += 2) begin
            if (batch_store[i] > batch_store[i+1]) begin
               t = batch_store[i];
               batch_store[i] = batch_store[i+1];
               batch_store[i+1] = t;
               swapped = 1'b1;
            end
         end
      end
   endfunction

   function automatic void absorb_element(value_type value, logic last);
      sorted_elem_type r;
      int              k;
      requests_taken++;
      if (batch_count < CAPACITY) begin
         batch_store[batch_count] = value;
         batch_count++;
      end else begin
         batch_dropped = 1'b1;
      end
      if (last) begin
         sort_batch(batch_count);
         for (k = 0; k < batch_count; k++) begin
            r.sorted_value = batch_store[k];
            r.final_res    = (k == batch_count - 1);
            r.overflow     = batch_dropped;
            sorted_due.push_back(r);
         end
         batches_done++;
         if (batch_dropped)
            overflow_batches++;
         batch_count   = 0;
         batch_dropped = 1'b0;
      end
   endfunction

   // driver: advance to the next request once the current one is taken
   always @(posedge clock) begin
      element_req_type nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.value <= '0;
         req_bus.last  <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            absorb_element(req_bus.value, req_bus.last);
         if (!req_bus.valid || req_bus.ready) begin
            if (element_feed.size() != 0 &&
                (no_idle || $urandom_range(99) >= IDLE_PERCENT)) begin
               nxt = element_feed.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.value <= nxt.value;
               req_bus.last  <= nxt.last;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // response ready, with an occasional long hold-off to back the block up
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left = 0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (holds_served != hold_requests) begin
         holds_served++;
         hold_left = HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // monitor
   always @(posedge clock) begin
      sorted_elem_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_checked++;
         if (sorted_due.size() == 0) begin
            $error("response with nothing pending: sorted_value %0d", rsp_bus.sorted_value);
            error_count++;
         end else begin
            want = sorted_due.pop_front();
            if (rsp_bus.sorted_value !== want.sorted_value) begin
               $error("sorted_value: expected %0d, got %0d",
                      want.sorted_value, rsp_bus.sorted_value);
               error_count++;
            end
            if (rsp_bus.final_res !== want.final_res) begin
               $error("final_res: expected %0b, got %0b", want.final_res, rsp_bus.final_res);
               error_count++;
            end
            if (rsp_bus.overflow !== want.overflow) begin
               $error("overflow: expected %0b, got %0b", want.overflow, rsp_bus.overflow);
               error_count++;
            end
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("run stopped after %0d cycles with %0d results outstanding",
               cycle_count, sorted_due.size());
      $display("TB_ERROR");
      $finish;
   end

   function automatic void push_element(value_type value, logic last);
      element_req_type e;
      e.value = value;
      e.last  = last;
      element_feed.push_back(e);
      items_queued++;
   endfunction

   // mostly full-range values, with extremes and a narrow band to force duplicates
   function automatic value_type pick_value();
      int sel;
      sel = $urandom_range(9);
      case (sel)
         0: begin
            case ($urandom_range(3))
               0:       return 32'sh8000_0000;
               1:       return 32'sh7fff_ffff;
               2:       return '0;
               default: return -32'sd1;
            endcase
         end
         1, 2, 3: return value_type'($urandom_range(30)) - 32'sd15;
         default: return value_type'($urandom);
      endcase
   endfunction

   function automatic void push_batch(int len);
      int i;
      for (i = 0; i < len; i++)
         push_element(pick_value(), i == len - 1);
   endfunction

   // small batches dominate; a few nearly or exactly fill the store or run past it
   function automatic int pick_length();
      int r;
      r = $urandom_range(99);
      if (r < 70)
         return $urandom_range(12, 1);
      else if (r < 85)
         return $urandom_range(40, 13);
      else if (r < 95)
         return $urandom_range(CAPACITY, CAPACITY - 1);
      else
         return $urandom_range(CAPACITY + 6, CAPACITY + 1);
   endfunction

   task automatic drain();
      while (element_feed.size() != 0 || req_bus.valid || sorted_due.size() != 0)
         @(posedge clock);
   endtask

   initial begin : stimulus
      int i;
      no_idle = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: lone element, extremes, reversed, duplicates, already sorted
      push_element('0, 1'b1);
      push_element(32'sh7fff_ffff, 1'b0);
      push_element(32'sh8000_0000, 1'b0);
      push_element(-32'sd1, 1'b0);
      push_element('0, 1'b0);
      push_element(32'sd1, 1'b1);
      for (i = 5; i >= 1; i--)
         push_element(value_type'(i), i == 1);
      for (i = 0; i < 5; i++)
         push_element((i % 2) ? -32'sd3 : 32'sd3, i == 4);
      push_element(32'sh8000_0000, 1'b0);
      push_element(-32'sd1, 1'b0);
      push_element('0, 1'b0);
      push_element(32'sd1, 1'b0);
      push_element(32'sh7fff_ffff, 1'b1);
      push_element(32'sd42, 1'b0);
      push_element(32'sd42, 1'b1);
      drain();

      // random with idling on both sides; one full store and one that overflows
      push_batch(CAPACITY);
      push_batch(CAPACITY + 3);
      while (items_queued < 250)
         push_batch(pick_length());
      drain();

      // hold nothing back for a stretch
      no_idle = 1'b1;
      while (items_queued < 380)
         push_batch(pick_length());
      drain();
      no_idle = 1'b0;

      // stall responses long enough that the next batch backs up at the input
      hold_requests++;
      push_batch(10);
      push_batch(20);
      drain();

      while (items_queued < ITEM_TARGET)
         push_batch(pick_length());
      drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (sorted_due.size() != 0) begin
         $error("%0d sorted results never arrived", sorted_due.size());
         error_count++;
      end
      $display("covered %0d batches from %0d requests, %0d of them overflowing the store;",
               batches_done, requests_taken, overflow_batches);
      $display("checked %0d sorted results in %0d cycles", results_checked, cycle_count);
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+hdl
hdl/oets_pkg.sv
hdl/oets_req_if.sv
hdl/oets_rsp_if.sv
hdl/oets_ctrl.sv
hdl/oets_datapath.sv
hdl/odd_even_transposition_sort.sv
tb/odd_even_transposition_sort_tb.sv
